>>> rtl/shape_rasterizer_top_assert.svh
// Assertion macros for the rasteriser top level.
// Both sample on clk_i and are switched off while rst_ni is low.
`ifndef SHAPE_RASTERIZER_TOP_ASSERT_SVH
`define SHAPE_RASTERIZER_TOP_ASSERT_SVH

// Property checked in the same cycle
`define SR_ASSERT_NOW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);

`endif

>>> rtl/sr_pkg.sv
`timescale 1ns / 1ps

package sr_pkg;

  localparam int MaxSide  = 512;
  localparam int FracBits = 8;

  localparam int SideW  = 10;                 // frame size registers
  localparam int ColW   = $clog2(MaxSide);    // pixel column / row index
  localparam int AddrW  = 2 * ColW;           // row * MaxSide + col
  localparam int FieldW = 19;                 // Q11.8 input fields
  localparam int CoordW = FieldW + 2;         // room for origin + extent +/- one
  localparam int ProdW  = 2 * CoordW - 2;     // signed product width
  localparam int SqW    = 2 * (FieldW + 1) - 2; // squared distance per axis
  localparam int D2W    = SqW + 1;            // sum of both axes

  localparam logic [1:0] CmdClear = 2'd0;
  localparam logic [1:0] CmdDraw  = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusBadShape = 2'd1;
  localparam logic [1:0] StatusOutside  = 2'd2;

  localparam logic [7:0] ShapeCircOut  = 8'h63; // 'c'
  localparam logic [7:0] ShapeCircFill = 8'h43; // 'C'
  localparam logic [7:0] ShapeRectOut  = 8'h72; // 'r'
  localparam logic [7:0] ShapeRectFill = 8'h52; // 'R'

  localparam logic [1:0] RegFrameWidth  = 2'd0;
  localparam logic [1:0] RegFrameHeight = 2'd1;
  localparam logic [1:0] RegBackground  = 2'd2;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_CIRCLE = 2'd1,
    MODE_RECT   = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e                     mode;
    logic                      outline;
    logic signed [FieldW-1:0]  ox;
    logic signed [FieldW-1:0]  oy;
    logic signed [FieldW-1:0]  ea;
    logic signed [FieldW-1:0]  eb;
  } shape_t;

  typedef struct packed {
    logic            valid;
    logic            last;
    logic [ColW-1:0] x;
    logic [ColW-1:0] y;
  } scan_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic             covered;
    logic [AddrW-1:0] addr;
  } pix_t;

endpackage

>>> rtl/sr_frame_mem.sv
`timescale 1ns / 1ps

module sr_frame_mem (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [sr_pkg::AddrW-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [sr_pkg::AddrW-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  localparam int Depth = 1 << sr_pkg::AddrW;

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sr_scan.sv
`timescale 1ns / 1ps

module sr_scan (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [sr_pkg::SideW-1:0] fw_i,
  input  logic [sr_pkg::SideW-1:0] fh_i,
  output sr_pkg::scan_t            scan_o
);

  logic [sr_pkg::ColW-1:0] x_q, y_q;
  logic                    run_q;
  logic                    x_last, y_last;

  assign x_last = (sr_pkg::SideW'(x_q) == fw_i - sr_pkg::SideW'(1));
  assign y_last = (sr_pkg::SideW'(y_q) == fh_i - sr_pkg::SideW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      x_q   <= '0;
      y_q   <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      x_q   <= '0;
      y_q   <= '0;
    end else if (run_q) begin
      if (x_last && y_last) begin
        run_q <= 1'b0;
      end else if (x_last) begin
        x_q <= '0;
        y_q <= y_q + sr_pkg::ColW'(1);
      end else begin
        x_q <= x_q + sr_pkg::ColW'(1);
      end
    end
  end

  assign scan_o.valid = run_q;
  assign scan_o.last  = run_q && x_last && y_last;
  assign scan_o.x     = x_q;
  assign scan_o.y     = y_q;

endmodule

>>> rtl/sr_cover.sv
`timescale 1ns / 1ps

// Two-stage coverage pipe: stage 1 takes offsets and edge compares,
// stage 2 holds the squares; the distance compare follows stage 2.
module sr_cover (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  sr_pkg::shape_t shape_i,
  input  sr_pkg::scan_t  scan_i,
  output sr_pkg::pix_t   pix_o
);

  localparam int CW = sr_pkg::CoordW;

  localparam logic signed [CW-1:0] One = CW'(1) <<< sr_pkg::FracBits;

  // per-shape constants, taken once before the scan
  logic [sr_pkg::D2W-1:0] r2_q, r1sq_q;
  logic                   r1_pos_q;
  logic signed [CW-1:0]   xlo_q, xhi_q, xilo_q, xihi_q;
  logic signed [CW-1:0]   ylo_q, yhi_q, yilo_q, yihi_q;

  logic signed [CW-1:0]      ox_w, oy_w, ea_w, eb_w, r1_w;
  logic signed [sr_pkg::ProdW-1:0] r2_w, r1sq_w;

  assign ox_w   = CW'(shape_i.ox);
  assign oy_w   = CW'(shape_i.oy);
  assign ea_w   = CW'(shape_i.ea);
  assign eb_w   = CW'(shape_i.eb);
  assign r1_w   = ea_w - One;
  assign r2_w   = sr_pkg::ProdW'(ea_w) * sr_pkg::ProdW'(ea_w);
  assign r1sq_w = sr_pkg::ProdW'(r1_w) * sr_pkg::ProdW'(r1_w);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      r2_q     <= r2_w[sr_pkg::D2W-1:0];
      r1sq_q   <= r1sq_w[sr_pkg::D2W-1:0];
      r1_pos_q <= !r1_w[CW-1];
      xlo_q    <= ox_w;
      xhi_q    <= ox_w + ea_w;
      xilo_q   <= ox_w + One;
      xihi_q   <= ox_w + ea_w - One;
      ylo_q    <= oy_w;
      yhi_q    <= oy_w + eb_w;
      yilo_q   <= oy_w + One;
      yihi_q   <= oy_w + eb_w - One;
    end
  end

  // stage 1
  logic signed [CW-1:0] px, py;
  logic                 in_outer, in_inner;

  assign px = CW'(scan_i.x) <<< sr_pkg::FracBits;
  assign py = CW'(scan_i.y) <<< sr_pkg::FracBits;

  assign in_outer = (px >= xlo_q) && (px <= xhi_q) && (py >= ylo_q) && (py <= yhi_q);
  assign in_inner = (px >= xilo_q) && (px <= xihi_q) && (py >= yilo_q) && (py <= yihi_q);

  logic                     s1_valid_q, s1_last_q, s1_rect_q;
  logic [sr_pkg::AddrW-1:0] s1_addr_q;
  logic signed [CW-1:0]     dx_q, dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= scan_i.valid;
      s1_last_q  <= scan_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= {scan_i.y, scan_i.x};
    s1_rect_q <= in_outer && !(shape_i.outline && in_inner);
    dx_q      <= px - ox_w;
    dy_q      <= py - oy_w;
  end

  // stage 2
  logic signed [sr_pkg::ProdW-1:0] dx2_w, dy2_w;

  assign dx2_w = sr_pkg::ProdW'(dx_q) * sr_pkg::ProdW'(dx_q);
  assign dy2_w = sr_pkg::ProdW'(dy_q) * sr_pkg::ProdW'(dy_q);

  logic                     s2_valid_q, s2_last_q, s2_rect_q;
  logic [sr_pkg::AddrW-1:0] s2_addr_q;
  logic [sr_pkg::SqW-1:0]   dx2_q, dy2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_last_q  <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
      s2_last_q  <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_addr_q <= s1_addr_q;
    s2_rect_q <= s1_rect_q;
    dx2_q     <= dx2_w[sr_pkg::SqW-1:0];
    dy2_q     <= dy2_w[sr_pkg::SqW-1:0];
  end

  logic [sr_pkg::D2W-1:0] d2;
  logic                   circ_cov;
  logic                   covered;

  assign d2 = sr_pkg::D2W'(dx2_q) + sr_pkg::D2W'(dy2_q);

  // outline ring drops the inner disc only when radius minus one is not negative
  assign circ_cov = (d2 <= r2_q) && !(shape_i.outline && r1_pos_q && (d2 <= r1sq_q));

  always_comb begin
    case (shape_i.mode)
      sr_pkg::MODE_CLEAR:  covered = 1'b1;
      sr_pkg::MODE_CIRCLE: covered = circ_cov;
      sr_pkg::MODE_RECT:   covered = s2_rect_q;
      default:             covered = 1'b0;
    endcase
  end

  assign pix_o.valid   = s2_valid_q;
  assign pix_o.last    = s2_last_q;
  assign pix_o.covered = covered;
  assign pix_o.addr    = s2_addr_q;

endmodule

>>> rtl/shape_rasterizer_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Payload
// s_axis   in         tuser: cmd, shape_code / tdata: origin, extents, fill, read pixel
// m_axis   out        tuser: status / tdata: pixel_byte
// cfg      in         cfg_index_i, cfg_data_i (frame_width, frame_height, background_byte)
//
// Clear and draw scan the frame one pixel per cycle through the single write port
// of the frame memory; draw first loads the shape constants in ST_SETUP.
// Read issues the memory read, captures the data in ST_READ_WAIT and hands it over.
// Rejected draws, empty frames and reads outside the frame go from idle to ST_DONE.
// Frame memory is not cleared by reset; no clearing pass runs.
// A new item is taken once the previous result sits in the output register.
module shape_rasterizer_top (
  input  logic          clk_i,
  input  logic          rst_ni,

  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [103:0]  s_axis_tdata,  // origin_x, origin_y, extent_a, extent_b,
                                       // fill_byte, read_col, read_row, zero pad
  input  logic [9:0]    s_axis_tuser,  // cmd, shape_code

  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [7:0]    m_axis_tdata,  // pixel_byte
  output logic [1:0]    m_axis_tuser,  // status

  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [9:0]    cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_SETUP     = 5'b00010,
    ST_SCAN      = 5'b00100,
    ST_READ_WAIT = 5'b01000,
    ST_DONE      = 5'b10000
  } state_e;

  localparam int SW = sr_pkg::SideW;
  localparam int FW = sr_pkg::FieldW;

  // configuration
  logic [SW-1:0] fw_q, fh_q;
  logic [7:0]    bg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= SW'(1);
      fh_q <= SW'(1);
      bg_q <= 8'd32;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sr_pkg::RegFrameWidth:  fw_q <= cfg_data_i;
        sr_pkg::RegFrameHeight: fh_q <= cfg_data_i;
        sr_pkg::RegBackground:  bg_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] fw_eff, fh_eff;
  logic          frame_empty;

  assign fw_eff = (fw_q > SW'(sr_pkg::MaxSide)) ? SW'(sr_pkg::MaxSide) : fw_q;
  assign fh_eff = (fh_q > SW'(sr_pkg::MaxSide)) ? SW'(sr_pkg::MaxSide) : fh_q;
  assign frame_empty = (fw_eff == '0) || (fh_eff == '0);

  // input item fields
  logic [1:0]                in_cmd;
  logic [7:0]                in_code;
  logic signed [FW-1:0]      in_ox, in_oy, in_ea, in_eb;
  logic [7:0]                in_fill;
  logic [sr_pkg::ColW-1:0]   in_col, in_row;

  assign in_cmd  = s_axis_tuser[1:0];
  assign in_code = s_axis_tuser[9:2];
  assign in_ox   = $signed(s_axis_tdata[18:0]);
  assign in_oy   = $signed(s_axis_tdata[37:19]);
  assign in_ea   = $signed(s_axis_tdata[56:38]);
  assign in_eb   = $signed(s_axis_tdata[75:57]);
  assign in_fill = s_axis_tdata[83:76];
  assign in_col  = s_axis_tdata[92:84];
  assign in_row  = s_axis_tdata[101:93];

  logic is_circ, is_rect, draw_bad, read_out;

  assign is_circ  = (in_code == sr_pkg::ShapeCircOut) || (in_code == sr_pkg::ShapeCircFill);
  assign is_rect  = (in_code == sr_pkg::ShapeRectOut) || (in_code == sr_pkg::ShapeRectFill);
  assign draw_bad = (!is_circ && !is_rect) || (in_ea <= FW'(0))
                    || (is_rect && (in_eb <= FW'(0)));
  assign read_out = (SW'(in_col) >= fw_eff) || (SW'(in_row) >= fh_eff);

  // control
  state_e         state_q, state_d;
  sr_pkg::shape_t shape_q, shape_d;
  logic [7:0]     wdata_q, wdata_d;
  logic [1:0]     res_status_q, res_status_d;
  logic [7:0]     res_pix_q, res_pix_d;
  logic           m_valid_q, m_valid_d;
  logic [1:0]     m_status_q, m_status_d;
  logic [7:0]     m_pix_q, m_pix_d;

  logic           s_fire, scan_start, cov_load, rd_en, mem_we;
  logic [7:0]     rd_data;
  sr_pkg::scan_t  scan;
  sr_pkg::pix_t   cov_px;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d      = state_q;
    shape_d      = shape_q;
    wdata_d      = wdata_q;
    res_status_d = res_status_q;
    res_pix_d    = res_pix_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_status_d   = m_status_q;
    m_pix_d      = m_pix_q;
    scan_start   = 1'b0;
    cov_load     = 1'b0;
    rd_en        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          shape_d.ox      = in_ox;
          shape_d.oy      = in_oy;
          shape_d.ea      = in_ea;
          shape_d.eb      = in_eb;
          shape_d.outline = (in_code == sr_pkg::ShapeCircOut)
                            || (in_code == sr_pkg::ShapeRectOut);
          res_status_d    = sr_pkg::StatusOk;
          res_pix_d       = '0;
          state_d         = ST_DONE;
          case (in_cmd)
            sr_pkg::CmdClear: begin
              shape_d.mode = sr_pkg::MODE_CLEAR;
              wdata_d      = bg_q;
              if (!frame_empty) begin
                scan_start = 1'b1;
                state_d    = ST_SCAN;
              end
            end
            sr_pkg::CmdDraw: begin
              shape_d.mode = is_circ ? sr_pkg::MODE_CIRCLE : sr_pkg::MODE_RECT;
              wdata_d      = in_fill;
              if (draw_bad) begin
                res_status_d = sr_pkg::StatusBadShape;
              end else if (!frame_empty) begin
                state_d = ST_SETUP;
              end
            end
            sr_pkg::CmdRead: begin
              if (read_out) begin
                res_status_d = sr_pkg::StatusOutside;
              end else begin
                rd_en   = 1'b1;
                state_d = ST_READ_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SETUP: begin
        cov_load   = 1'b1;
        scan_start = 1'b1;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        if (cov_px.valid && cov_px.last) begin
          state_d = ST_DONE;
        end
      end
      ST_READ_WAIT: begin
        res_pix_d = rd_data;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_pix_d    = res_pix_q;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shape_q      <= shape_d;
    wdata_q      <= wdata_d;
    res_status_q <= res_status_d;
    res_pix_q    <= res_pix_d;
    m_status_q   <= m_status_d;
    m_pix_q      <= m_pix_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = m_pix_q;

  sr_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .fw_i    (fw_eff),
    .fh_i    (fh_eff),
    .scan_o  (scan)
  );

  sr_cover u_cover (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (cov_load),
    .shape_i (shape_q),
    .scan_i  (scan),
    .pix_o   (cov_px)
  );

  assign mem_we = cov_px.valid && cov_px.covered;

  sr_frame_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cov_px.addr),
    .wdata_i (wdata_q),
    .re_i    (rd_en),
    .raddr_i ({in_row, in_col}),
    .rdata_o (rd_data)
  );

  `include "shape_rasterizer_top_assert.svh"

  `SR_ASSERT_NOW(a_we_in_scan, mem_we |-> (state_q == ST_SCAN), "frame write outside a scan")
  `SR_ASSERT_NOW(a_last_in_scan, cov_px.last |-> (state_q == ST_SCAN), "scan end outside a scan")
  `SR_ASSERT_NEXT(a_busy_after_take, s_fire, !s_axis_tready, "item taken while busy")
  `SR_ASSERT_NEXT(a_read_capture, s_fire && rd_en, state_q == ST_READ_WAIT, "read lost")

endmodule

>>> tb/tb_shape_rasterizer_top.sv
`timescale 1ns / 1ps

module tb_shape_rasterizer_top;

  localparam logic [1:0] CmdIgnored = 2'd3;  // spare opcode, block answers status ok
  localparam logic [1:0] RegSpare   = 2'd3;
  localparam int PixelStep  = 1 << sr_pkg::FracBits;
  localparam int CycleLimit = 3_000_000;

  typedef struct {
    logic [1:0]                       op;
    logic [7:0]                       shape;
    logic signed [sr_pkg::FieldW-1:0] ox;
    logic signed [sr_pkg::FieldW-1:0] oy;
    logic signed [sr_pkg::FieldW-1:0] ea;
    logic signed [sr_pkg::FieldW-1:0] eb;
    logic [7:0]                       fill;
    logic [sr_pkg::ColW-1:0]          col;
    logic [sr_pkg::ColW-1:0]          row;
  } raster_cmd_t;

  typedef struct {
    logic [1:0] status;
    logic [7:0] pixel;
  } raster_reply_t;

  class raster_scoreboard;
    bit [7:0]                 pixels [sr_pkg::MaxSide*sr_pkg::MaxSide];
    bit                       touched [sr_pkg::MaxSide*sr_pkg::MaxSide];
    logic [sr_pkg::SideW-1:0] width_reg;
    logic [sr_pkg::SideW-1:0] height_reg;
    logic [7:0]               background;
    raster_reply_t            awaited [$];
    int                       errors;

    function new();
      width_reg  = 1;
      height_reg = 1;
      background = 8'd32;
      errors     = 0;
    endfunction

    function int cols();
      return (width_reg > sr_pkg::MaxSide) ? sr_pkg::MaxSide : int'(width_reg);
    endfunction

    function int rows();
      return (height_reg > sr_pkg::MaxSide) ? sr_pkg::MaxSide : int'(height_reg);
    endfunction

    function void write_reg(logic [1:0] idx, logic [9:0] data);
      case (idx)
        sr_pkg::RegFrameWidth:  width_reg = data;
        sr_pkg::RegFrameHeight: height_reg = data;
        sr_pkg::RegBackground:  background = data[7:0];
        default: ;
      endcase
    endfunction

    // pixel sits on the integer grid point, everything in Q fixed point
    function bit shape_covers(logic [7:0] code, longint px, longint py, longint ox,
                              longint oy, longint ea, longint eb);
      longint one;
      longint d2;
      longint r1;
      one = longint'(PixelStep);
      if (code == sr_pkg::ShapeCircOut || code == sr_pkg::ShapeCircFill) begin
        d2 = (px - ox) * (px - ox) + (py - oy) * (py - oy);
        r1 = ea - one;
        if (d2 > ea * ea) return 1'b0;
        if (code == sr_pkg::ShapeCircOut && r1 >= 0 && d2 <= r1 * r1) return 1'b0;
        return 1'b1;
      end
      if (px < ox || ox + ea < px || py < oy || oy + eb < py) return 1'b0;
      if (code == sr_pkg::ShapeRectOut && ox + one <= px && px <= ox + ea - one &&
          oy + one <= py && py <= oy + eb - one) return 1'b0;
      return 1'b1;
    endfunction

    function void note_command(raster_cmd_t c);
      raster_reply_t r;
      int fw;
      int fh;
      int idx;
      bit circ;
      bit rect;
      longint ox;
      longint oy;
      longint ea;
      longint eb;
      fw = cols();
      fh = rows();
      r.status = sr_pkg::StatusOk;
      r.pixel  = 8'd0;
      ox = longint'(c.ox);
      oy = longint'(c.oy);
      ea = longint'(c.ea);
      eb = longint'(c.eb);
      case (c.op)
        sr_pkg::CmdClear: begin
          for (int y = 0; y < fh; y++)
            for (int x = 0; x < fw; x++) begin
              pixels[y * sr_pkg::MaxSide + x]  = background;
              touched[y * sr_pkg::MaxSide + x] = 1'b1;
            end
        end
        sr_pkg::CmdDraw: begin
          circ = (c.shape == sr_pkg::ShapeCircOut || c.shape == sr_pkg::ShapeCircFill);
          rect = (c.shape == sr_pkg::ShapeRectOut || c.shape == sr_pkg::ShapeRectFill);
          if ((!circ && !rect) || ea <= 0 || (rect && eb <= 0)) begin
            r.status = sr_pkg::StatusBadShape;
          end else begin
            for (int y = 0; y < fh; y++)
              for (int x = 0; x < fw; x++)
                if (shape_covers(c.shape, longint'(x) * PixelStep, longint'(y) * PixelStep,
                                 ox, oy, ea, eb)) begin
                  pixels[y * sr_pkg::MaxSide + x]  = c.fill;
                  touched[y * sr_pkg::MaxSide + x] = 1'b1;
                end
          end
        end
        sr_pkg::CmdRead: begin
          if (int'(c.col) >= fw || int'(c.row) >= fh) begin
            r.status = sr_pkg::StatusOutside;
          end else begin
            idx = int'(c.row) * sr_pkg::MaxSide + int'(c.col);
            r.pixel = pixels[idx];
          end
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    function void check_reply(logic [1:0] status, logic [7:0] pixel);
      raster_reply_t want;
      if (awaited.size() == 0) begin
        $error("result with nothing pending: status %0d pixel %0h", status, pixel);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (pixel !== want.pixel) begin
        $error("pixel_byte: expected %0h, got %0h", want.pixel, pixel);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;   // origin_x, origin_y, extent_a, extent_b,
                                // fill_byte, read_col, read_row, zero pad
  logic [9:0]   s_axis_tuser;   // cmd, shape_code
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;   // pixel_byte
  logic [1:0]   m_axis_tuser;   // status
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i;
  logic [9:0]   cfg_data_i;

  raster_scoreboard sb;
  bit idling = 1'b1;
  int stall_left = 0;
  int cycles = 0;

  shape_rasterizer_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver back-pressure in short bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      stall_left    <= $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tuser, m_axis_tdata);
  end

  function automatic raster_cmd_t make_cmd(logic [1:0] op, logic [7:0] shape, int ox, int oy,
                                           int ea, int eb, logic [7:0] fill, int col, int row);
    raster_cmd_t c;
    c.op    = op;
    c.shape = shape;
    c.ox    = sr_pkg::FieldW'(ox);
    c.oy    = sr_pkg::FieldW'(oy);
    c.ea    = sr_pkg::FieldW'(ea);
    c.eb    = sr_pkg::FieldW'(eb);
    c.fill  = fill;
    c.col   = sr_pkg::ColW'(col);
    c.row   = sr_pkg::ColW'(row);
    return c;
  endfunction

  function automatic logic [7:0] pick_shape();
    case ($urandom_range(0, 3))
      0:       return sr_pkg::ShapeCircOut;
      1:       return sr_pkg::ShapeCircFill;
      2:       return sr_pkg::ShapeRectOut;
      default: return sr_pkg::ShapeRectFill;
    endcase
  endfunction

  function automatic raster_cmd_t random_command();
    raster_cmd_t c;
    int fw;
    int fh;
    int pick;
    int frac;
    fw = sb.cols();
    fh = sb.rows();
    c.op    = sr_pkg::CmdDraw;
    c.shape = 8'($urandom);
    c.ox    = sr_pkg::FieldW'($urandom);
    c.oy    = sr_pkg::FieldW'($urandom);
    c.ea    = sr_pkg::FieldW'($urandom);
    c.eb    = sr_pkg::FieldW'($urandom);
    c.fill  = 8'($urandom);
    c.col   = sr_pkg::ColW'($urandom);
    c.row   = sr_pkg::ColW'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // sensible shape near the frame; a third snap to whole pixels
      frac = ($urandom_range(0, 2) == 0) ? 0 : PixelStep - 1;
      c.shape = pick_shape();
      c.ox = sr_pkg::FieldW'((int'($urandom_range(0, fw + 8)) - 4) * PixelStep
                             + $urandom_range(0, frac));
      c.oy = sr_pkg::FieldW'((int'($urandom_range(0, fh + 8)) - 4) * PixelStep
                             + $urandom_range(0, frac));
      if (frac == 0) begin
        c.ea = sr_pkg::FieldW'($urandom_range(1, 12) * PixelStep);
        c.eb = sr_pkg::FieldW'($urandom_range(1, 12) * PixelStep);
      end else begin
        c.ea = sr_pkg::FieldW'($urandom_range(1, 12 * PixelStep));
        c.eb = sr_pkg::FieldW'($urandom_range(1, 12 * PixelStep));
      end
    end else if (pick < 80) begin
      c.op = sr_pkg::CmdRead;
      if ($urandom_range(0, 9) != 0) begin
        c.col = sr_pkg::ColW'($urandom_range(0, fw));
        c.row = sr_pkg::ColW'($urandom_range(0, fh));
      end
    end else if (pick < 85) begin
      c.op = sr_pkg::CmdClear;
    end else if (pick < 92) begin
      // raw draw, every field random
    end else if (pick < 96) begin
      c.shape = pick_shape();
      c.ea = sr_pkg::FieldW'($urandom_range(1, 4 * PixelStep));
      if ($urandom_range(0, 1) == 0) begin
        c.ea = sr_pkg::FieldW'(-int'($urandom_range(0, 4 * PixelStep)));
      end else begin
        c.eb = sr_pkg::FieldW'(-int'($urandom_range(0, 4 * PixelStep)));
      end
    end else begin
      c.op = CmdIgnored;
    end
    // never read a pixel nothing has written
    if (c.op == sr_pkg::CmdRead && int'(c.col) < fw && int'(c.row) < fh &&
        !sb.touched[int'(c.row) * sr_pkg::MaxSide + int'(c.col)]) c.op = sr_pkg::CmdClear;
    return c;
  endfunction

  task automatic send_command(raster_cmd_t c);
    int gap;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, c.row, c.col, c.fill, c.eb, c.ea, c.oy, c.ox};
    s_axis_tuser  <= {c.shape, c.op};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(c);
  endtask

  task automatic send_clear();
    send_command(make_cmd(sr_pkg::CmdClear, 8'h00, 0, 0, 0, 0, 8'h00, 0, 0));
  endtask

  task automatic send_draw(logic [7:0] shape, int ox, int oy, int ea, int eb, logic [7:0] fill);
    send_command(make_cmd(sr_pkg::CmdDraw, shape, ox, oy, ea, eb, fill, 0, 0));
  endtask

  task automatic send_read(int col, int row);
    send_command(make_cmd(sr_pkg::CmdRead, 8'h00, 0, 0, 0, 0, 8'h00, col, row));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(int w, int h, int bg);
    write_reg(sr_pkg::RegFrameWidth, 10'(w));
    write_reg(sr_pkg::RegFrameHeight, 10'(h));
    write_reg(sr_pkg::RegBackground, 10'(bg));
  endtask

  // wait for every pending result, then give the block time to settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values: 1x1 frame, space as background
    send_clear();
    send_read(0, 0);
    send_read(1, 0);
    send_read(0, 1);
    send_draw(sr_pkg::ShapeRectFill, 0, 0, PixelStep, PixelStep, 8'h41);
    send_read(0, 0);
    drain();

    // upper config bits beyond the byte are dropped
    configure(16, 12, 10'h12E);
    send_clear();
    send_read(0, 0);
    send_draw(sr_pkg::ShapeCircFill, 5 * PixelStep, 5 * PixelStep, 3 * PixelStep, 0, 8'h23);
    send_read(5, 5);
    send_read(5, 8);                      // exactly on the radius
    send_draw(sr_pkg::ShapeCircOut, 11 * PixelStep, 6 * PixelStep, 4 * PixelStep, 262143,
              8'h6F);
    send_read(11, 2);
    send_read(11, 6);                     // hollow centre
    // radius under one pixel: outline degenerates to a filled disc
    send_draw(sr_pkg::ShapeCircOut, 2 * PixelStep, 10 * PixelStep, PixelStep / 2, 0, 8'h78);
    send_read(2, 10);
    send_draw(sr_pkg::ShapeRectFill, PixelStep, PixelStep, 3 * PixelStep, 2 * PixelStep, 8'h52);
    send_read(4, 3);
    send_draw(sr_pkg::ShapeRectOut, 8 * PixelStep, 0, 6 * PixelStep, 5 * PixelStep, 8'h2B);
    send_read(11, 2);
    send_draw(sr_pkg::ShapeRectOut, 0, 9 * PixelStep, PixelStep, PixelStep, 8'h3D);
    send_read(1, 10);
    send_draw(8'h78, 0, 0, 4 * PixelStep, 4 * PixelStep, 8'h55);       // unknown shape
    send_draw(sr_pkg::ShapeCircFill, 3 * PixelStep, 3 * PixelStep, 0, 0, 8'h55);
    send_draw(sr_pkg::ShapeCircOut, 3 * PixelStep, 3 * PixelStep, -262144, 0, 8'h55);
    send_draw(sr_pkg::ShapeRectFill, 0, 0, 4 * PixelStep, 0, 8'h55);
    send_draw(sr_pkg::ShapeRectOut, 0, 0, -PixelStep, PixelStep, 8'h55);
    send_draw(sr_pkg::ShapeCircFill, 262143, -262144, 262143, 0, 8'hFF);
    send_draw(sr_pkg::ShapeRectFill, -262144, -262144, 262143, 262143, 8'h00);
    send_draw(sr_pkg::ShapeRectFill, -2 * PixelStep + 1, -PixelStep, 262143, 262143, 8'h2A);
    send_read(15, 11);
    send_read(16, 0);
    send_read(511, 511);
    send_command(make_cmd(CmdIgnored, 8'hFF, -1, -1, -1, -1, 8'hFF, 511, 511));
    drain();

    // empty frame: nothing drawn, every read outside
    configure(0, 7, 0);
    send_clear();
    send_draw(sr_pkg::ShapeRectFill, -PixelStep, -PixelStep, 20 * PixelStep, 20 * PixelStep,
              8'h21);
    send_read(0, 0);
    drain();

    // width saturates at the maximum
    configure(10'h3FF, 1, 10'h3FF);
    send_clear();
    send_draw(sr_pkg::ShapeCircFill, 300 * PixelStep, 0, 40 * PixelStep, 0, 8'h40);
    send_read(300, 0);
    send_read(511, 0);
    send_read(0, 1);
    drain();

    write_reg(RegSpare, 10'h2AA);
    configure(1, 10'h3FF, 10'h155);
    send_clear();
    send_draw(sr_pkg::ShapeRectOut, 0, 100 * PixelStep, PixelStep, 300 * PixelStep, 8'h7E);
    send_read(0, 511);
    send_read(0, 200);
    send_read(0, 100);
    drain();

    configure(sr_pkg::MaxSide, sr_pkg::MaxSide, 0);
    send_clear();
    send_draw(sr_pkg::ShapeCircOut, 256 * PixelStep, 256 * PixelStep, 200 * PixelStep, 0,
              8'h6F);
    send_read(256, 56);
    send_read(256, 256);
    send_read(511, 511);
    drain();

    for (int p = 0; p < 5; p++) begin
      idling = (p < 4);
      configure($urandom_range(1, 24), $urandom_range(1, 24), $urandom_range(0, 1023));
      send_clear();
      repeat (10) send_command(random_command());
      drain();
    end

    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> shape_rasterizer_top.f
+incdir+rtl
rtl/sr_pkg.sv
rtl/sr_frame_mem.sv
rtl/sr_scan.sv
rtl/sr_cover.sv
rtl/shape_rasterizer_top.sv
tb/tb_shape_rasterizer_top.sv
